>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mbet_pkg.sv
`timescale 1ns / 1ps

package mbet_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS     = 28;
    localparam int COUNT_WIDTH   = 16;
    localparam int GRAY_WIDTH    = 8;
    localparam int PROD_WIDTH    = 2 * COORD_WIDTH;
    localparam int MAG_WIDTH     = PROD_WIDTH + 1;
    localparam int SUM_WIDTH     = COORD_WIDTH + 4;
    localparam int NUM_WIDTH     = COUNT_WIDTH + GRAY_WIDTH;
    localparam int BIT_IDX_WIDTH = $clog2(GRAY_WIDTH);

    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(256);

    // |z|^2 limit of 4 with 2*FRAC_BITS fraction bits
    localparam logic [MAG_WIDTH-1:0] ESC_LIMIT =
        {{(MAG_WIDTH-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
        {{(SUM_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SAT_LO =
        {{(SUM_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPDATE,
        ST_DIV,
        ST_FIN
    } mbet_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic update;
        logic div_start;
        logic div_step;
        logic out_load;
    } mbet_cmd_t;

    typedef struct packed {
        logic at_limit;
        logic escape;
        logic div_last;
    } mbet_status_t;

endpackage

>>> sv/mbet_ctrl.sv
`timescale 1ns / 1ps

module mbet_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  mbet_pkg::mbet_status_t status,
    output mbet_pkg::mbet_cmd_t    cmd
);

    mbet_pkg::mbet_state_t state_reg;
    mbet_pkg::mbet_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbet_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbet_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = mbet_pkg::ST_MUL;
            end
            mbet_pkg::ST_MUL:
            begin
                if (status.at_limit)
                    state_next = mbet_pkg::ST_DIV;
                else
                    state_next = mbet_pkg::ST_UPDATE;
            end
            mbet_pkg::ST_UPDATE:
            begin
                if (status.escape)
                    state_next = mbet_pkg::ST_DIV;
                else
                    state_next = mbet_pkg::ST_MUL;
            end
            mbet_pkg::ST_DIV:
            begin
                if (status.div_last)
                    state_next = mbet_pkg::ST_FIN;
            end
            mbet_pkg::ST_FIN:
            begin
                if (out_free)
                    state_next = mbet_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mbet_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            mbet_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            mbet_pkg::ST_MUL:
            begin
                cmd.mul       = !status.at_limit;
                cmd.div_start = status.at_limit;
            end
            mbet_pkg::ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.div_start = status.escape;
            end
            mbet_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            mbet_pkg::ST_FIN:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // hold the result until taken, refill on load
    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

endmodule

>>> sv/mbet_datapath.sv
`timescale 1ns / 1ps

module mbet_datapath (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic        [mbet_pkg::COUNT_WIDTH-1:0]    cfg_wr_data,
    input  logic signed [mbet_pkg::COORD_WIDTH-1:0]    c_real,
    input  logic signed [mbet_pkg::COORD_WIDTH-1:0]    c_imag,
    input  mbet_pkg::mbet_cmd_t                        cmd,
    output mbet_pkg::mbet_status_t                     status,
    output logic        [mbet_pkg::COUNT_WIDTH-1:0]    iteration_count,
    output logic        [mbet_pkg::GRAY_WIDTH-1:0]     gray_level,
    output logic                                       escaped
);

    localparam int CW = mbet_pkg::COORD_WIDTH;
    localparam int SW = mbet_pkg::SUM_WIDTH;
    localparam int PW = mbet_pkg::PROD_WIDTH;
    localparam int MW = mbet_pkg::MAG_WIDTH;
    localparam int NW = mbet_pkg::NUM_WIDTH;
    localparam int GW = mbet_pkg::GRAY_WIDTH;
    localparam int KW = mbet_pkg::COUNT_WIDTH;
    localparam int BW = mbet_pkg::BIT_IDX_WIDTH;
    localparam int FB = mbet_pkg::FRAC_BITS;

    logic        [KW-1:0] limit_reg;
    logic signed [CW-1:0] cr_reg;
    logic signed [CW-1:0] ci_reg;
    logic signed [CW-1:0] zr_reg;
    logic signed [CW-1:0] zi_reg;
    logic        [KW-1:0] count_reg;
    logic                 esc_flag_reg;
    logic        [PW-1:0] prod_rr_reg;
    logic        [PW-1:0] prod_ii_reg;
    logic        [PW-1:0] prod_x_reg;
    logic                 cross_neg_reg;
    logic        [NW-1:0] num_reg;
    logic        [GW-1:0] quot_reg;
    logic        [BW-1:0] div_bit_reg;
    logic        [KW-1:0] iteration_count_reg;
    logic        [GW-1:0] gray_level_reg;
    logic                 escaped_reg;

    logic        [CW-1:0] mag_r;
    logic        [CW-1:0] mag_i;
    logic        [MW-1:0] mag_sum;
    logic        [PW-1:0] sq_r_full;
    logic        [PW-1:0] sq_i_full;
    logic        [MW-1:0] cross_full;
    logic signed [SW-1:0] sq_r;
    logic signed [SW-1:0] sq_i;
    logic signed [SW-1:0] cross_mag;
    logic signed [SW-1:0] cross_val;
    logic signed [SW-1:0] cr_ext;
    logic signed [SW-1:0] ci_ext;
    logic signed [SW-1:0] new_r_sum;
    logic signed [SW-1:0] new_i_sum;
    logic        [NW-1:0] num_init;
    logic        [NW-1:0] divisor_shift;
    logic        [NW:0]   trial;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > mbet_pkg::SAT_HI)
            r = mbet_pkg::SAT_HI;
        else if (v < mbet_pkg::SAT_LO)
            r = mbet_pkg::SAT_LO;
        else
            r = v;
        return r[CW-1:0];
    endfunction

    assign mag_r = zr_reg[CW-1] ? (~zr_reg + 1'b1) : zr_reg;
    assign mag_i = zi_reg[CW-1] ? (~zi_reg + 1'b1) : zi_reg;

    assign mag_sum = {1'b0, prod_rr_reg} + {1'b0, prod_ii_reg};

    assign sq_r_full  = prod_rr_reg >> FB;
    assign sq_i_full  = prod_ii_reg >> FB;
    assign cross_full = {prod_x_reg, 1'b0} >> FB;

    assign sq_r      = {1'b0, sq_r_full[SW-2:0]};
    assign sq_i      = {1'b0, sq_i_full[SW-2:0]};
    assign cross_mag = {1'b0, cross_full[SW-2:0]};
    assign cross_val = cross_neg_reg ? -cross_mag : cross_mag;

    assign cr_ext = {{(SW-CW){cr_reg[CW-1]}}, cr_reg};
    assign ci_ext = {{(SW-CW){ci_reg[CW-1]}}, ci_reg};

    assign new_r_sum = sq_r - sq_i + cr_ext;
    assign new_i_sum = cross_val + ci_ext;

    // count*255 as count*256 - count
    assign num_init      = {count_reg, {GW{1'b0}}} - {{GW{1'b0}}, count_reg};
    assign divisor_shift = {{GW{1'b0}}, limit_reg} << div_bit_reg;
    assign trial         = {1'b0, num_reg} - {1'b0, divisor_shift};

    assign status.at_limit = count_reg >= limit_reg;
    assign status.escape   = mag_sum > mbet_pkg::ESC_LIMIT;
    assign status.div_last = div_bit_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= mbet_pkg::MAX_ITER_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg       <= c_real;
            ci_reg       <= c_imag;
            zr_reg       <= '0;
            zi_reg       <= '0;
            count_reg    <= '0;
            esc_flag_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            if (status.escape)
                esc_flag_reg <= 1'b1;
            else
            begin
                zr_reg    <= sat_coord(new_r_sum);
                zi_reg    <= sat_coord(new_i_sum);
                count_reg <= count_reg + 1'b1;
            end
        end

        if (cmd.mul)
        begin
            prod_rr_reg   <= mag_r * mag_r;
            prod_ii_reg   <= mag_i * mag_i;
            prod_x_reg    <= mag_r * mag_i;
            cross_neg_reg <= zr_reg[CW-1] ^ zi_reg[CW-1];
        end

        if (cmd.div_start)
        begin
            num_reg     <= num_init;
            quot_reg    <= '0;
            div_bit_reg <= BW'(GW - 1);
        end
        else if (cmd.div_step)
        begin
            if (!trial[NW])
            begin
                num_reg               <= trial[NW-1:0];
                quot_reg[div_bit_reg] <= 1'b1;
            end
            div_bit_reg <= div_bit_reg - 1'b1;
        end

        if (cmd.out_load)
        begin
            iteration_count_reg <= count_reg;
            gray_level_reg      <= (limit_reg == '0) ? '0 : quot_reg;
            escaped_reg         <= esc_flag_reg;
        end
    end

    assign iteration_count = iteration_count_reg;
    assign gray_level      = gray_level_reg;
    assign escaped         = escaped_reg;

endmodule

>>> sv/mandelbrot_escape_time.sv
// Escape-time iteration for one point c of the Mandelbrot set.
// Request channel: in_valid / in_stall with c_real, c_imag (signed Q4.28).
// Result channel: out_valid / out_stall with iteration_count, gray_level,
// escaped. One result per request.
// Configuration: cfg_wr_en / cfg_wr_data write max_iterations (reset 256).
// Each iteration has a product state for the three 32x32 products and an
// update state for the escape test and the saturating update of z. The gray
// level then comes from a restoring divider, one quotient bit per cycle.
// One request is in work at a time; the next is accepted in the cycle after
// the result is loaded into the output register.
// A stalled result holds in the output register while the next request is
// worked; the finished result waits in ST_FIN until the register frees.
// Reset clears the controller and output valid and sets the limit to 256.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mandelbrot_escape_time (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic        [mbet_pkg::COUNT_WIDTH-1:0] cfg_wr_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [mbet_pkg::COORD_WIDTH-1:0] c_real,
    input  logic signed [mbet_pkg::COORD_WIDTH-1:0] c_imag,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic        [mbet_pkg::COUNT_WIDTH-1:0] iteration_count,
    output logic        [mbet_pkg::GRAY_WIDTH-1:0]  gray_level,
    output logic                                    escaped
);

    mbet_pkg::mbet_cmd_t    dp_cmd;
    mbet_pkg::mbet_status_t dp_status;

    mbet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    mbet_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .cmd             (dp_cmd),
        .status          (dp_status),
        .iteration_count (iteration_count),
        .gray_level      (gray_level),
        .escaped         (escaped)
    );

    `ASSERT_IMP(a_update_after_mul, clk, rst_n, dp_cmd.update, $past(dp_cmd.mul), "update without products")
    `ASSERT_IMP(a_no_overwrite, clk, rst_n, dp_cmd.out_load, !(out_valid && out_stall), "result overwritten")
    `ASSERT_IMP(a_zero_gray, clk, rst_n, out_valid && (iteration_count == '0), gray_level == '0, "gray not zero")
    `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "request taken while busy")

endmodule

>>> tb/tb_mandelbrot_escape_time.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;

    localparam int GRAY_FULL = 255;

    typedef struct packed {
        logic [mbet_pkg::COUNT_WIDTH-1:0] count;
        logic [mbet_pkg::GRAY_WIDTH-1:0]  gray;
        logic                             escaped;
    } point_result_t;

    typedef struct packed {
        int                               limit;
        logic [mbet_pkg::COORD_WIDTH-1:0] cr;
        logic [mbet_pkg::COORD_WIDTH-1:0] ci;
        bit                               known;
        point_result_t                    res;
    } stim_row_t;

    logic                                    clk;
    logic                                    rst_n       = 1'b0;
    logic                                    cfg_wr_en   = 1'b0;
    logic [mbet_pkg::COUNT_WIDTH-1:0]        cfg_wr_data = '0;
    logic                                    in_valid    = 1'b0;
    logic                                    in_stall;
    logic signed [mbet_pkg::COORD_WIDTH-1:0] c_real      = '0;
    logic signed [mbet_pkg::COORD_WIDTH-1:0] c_imag      = '0;
    logic                                    out_valid;
    logic                                    out_stall   = 1'b0;
    logic [mbet_pkg::COUNT_WIDTH-1:0]        iteration_count;
    logic [mbet_pkg::GRAY_WIDTH-1:0]         gray_level;
    logic                                    escaped;

    point_result_t                    awaited[$];
    stim_row_t                        stim_rows[$];
    logic [mbet_pkg::COUNT_WIDTH-1:0] iter_limit = mbet_pkg::MAX_ITER_RESET;
    int                               errors     = 0;
    int                               send_pct   = 30;
    int                               stall_pct  = 30;

    mandelbrot_escape_time u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .iteration_count (iteration_count),
        .gray_level      (gray_level),
        .escaped         (escaped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [127:0] clamp_coord(input logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (mbet_pkg::COORD_WIDTH - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic point_result_t escape_time(
        input logic signed [mbet_pkg::COORD_WIDTH-1:0] cr,
        input logic signed [mbet_pkg::COORD_WIDTH-1:0] ci,
        input logic [mbet_pkg::COUNT_WIDTH-1:0]        lim);
        point_result_t       r;
        logic signed [127:0] zr;
        logic signed [127:0] zi;
        logic signed [127:0] sq_r;
        logic signed [127:0] sq_i;
        logic signed [127:0] cross_term;
        logic [127:0]        mr;
        logic [127:0]        mi;
        logic [127:0]        rr;
        logic [127:0]        ii;
        logic [127:0]        xx;
        int unsigned         count;
        bit                  out_of_circle;
        zr = '0;
        zi = '0;
        count = 0;
        out_of_circle = 1'b0;
        while (count < lim)
        begin
            mr = (zr < 0) ? -zr : zr;
            mi = (zi < 0) ? -zi : zi;
            rr = mr * mr;
            ii = mi * mi;
            if (rr + ii > (128'd1 << (2 * mbet_pkg::FRAC_BITS + 2)))
            begin
                out_of_circle = 1'b1;
                break;
            end
            sq_r = $signed(rr >> mbet_pkg::FRAC_BITS);
            sq_i = $signed(ii >> mbet_pkg::FRAC_BITS);
            xx = (mr * mi * 128'd2) >> mbet_pkg::FRAC_BITS;
            cross_term = ((zr < 0) != (zi < 0)) ? -$signed(xx) : $signed(xx);
            zr = clamp_coord(sq_r - sq_i + cr);
            zi = clamp_coord(cross_term + ci);
            count++;
        end
        r.count = mbet_pkg::COUNT_WIDTH'(count);
        r.gray = (lim == 0) ? '0 : mbet_pkg::GRAY_WIDTH'((count * GRAY_FULL) / lim);
        r.escaped = out_of_circle;
        return r;
    endfunction

    function automatic int idle_len(input int pct);
        int r;
        r = $urandom_range(0, 99);
        if (r >= pct)
            return 0;
        if (r < pct / 8)
            return $urandom_range(12, 60);
        return $urandom_range(1, 3);
    endfunction

    initial
    begin
        int left;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left > 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else
            begin
                out_stall <= 1'b0;
                left = idle_len(stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        point_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited.size() == 0)
            begin
                $error("result with no request pending: count %0d", iteration_count);
                errors++;
            end
            else
            begin
                want = awaited.pop_front();
                if (iteration_count !== want.count)
                begin
                    $error("iteration_count: expected %0d, got %0d", want.count,
                           iteration_count);
                    errors++;
                end
                if (gray_level !== want.gray)
                begin
                    $error("gray_level: expected %0d, got %0d", want.gray, gray_level);
                    errors++;
                end
                if (escaped !== want.escaped)
                begin
                    $error("escaped: expected %0d, got %0d", want.escaped, escaped);
                    errors++;
                end
            end
        end
    end

    task automatic send_point(input logic [mbet_pkg::COORD_WIDTH-1:0] cr,
                              input logic [mbet_pkg::COORD_WIDTH-1:0] ci,
                              input point_result_t res);
        int gap;
        gap = idle_len(send_pct);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        c_real   <= cr;
        c_imag   <= ci;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited.push_back(res);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [mbet_pkg::COUNT_WIDTH-1:0] lim);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        iter_limit = lim;
    endtask

    task automatic add_row(input int lim, input logic [mbet_pkg::COORD_WIDTH-1:0] cr,
                           input logic [mbet_pkg::COORD_WIDTH-1:0] ci, input bit known,
                           input int cnt, input int gray, input bit esc);
        stim_row_t row;
        row.limit = lim;
        row.cr = cr;
        row.ci = ci;
        row.known = known;
        row.res.count = mbet_pkg::COUNT_WIDTH'(cnt);
        row.res.gray = mbet_pkg::GRAY_WIDTH'(gray);
        row.res.escaped = esc;
        stim_rows.push_back(row);
    endtask

    initial
    begin
        stim_row_t                        row;
        logic [mbet_pkg::COORD_WIDTH-1:0] cr;
        logic [mbet_pkg::COORD_WIDTH-1:0] ci;
        int                               sent;
        int                               n;
        int                               pick;

        //      limit  c_real        c_imag        known count  gray esc
        add_row(-1,    32'h0000_0000, 32'h0000_0000, 1, 256,   255, 0);
        add_row(-1,    32'h7FFF_FFFF, 32'h0000_0000, 1, 1,     0,   1);
        add_row(-1,    32'h8000_0000, 32'h8000_0000, 1, 1,     0,   1);
        add_row(-1,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1,     0,   1);
        add_row(-1,    32'h0000_0000, 32'h8000_0000, 1, 1,     0,   1);
        add_row(-1,    32'hE000_0000, 32'h0000_0000, 1, 256,   255, 0);
        add_row(-1,    32'h2000_0000, 32'h0000_0000, 1, 2,     1,   1);
        add_row(-1,    32'h0400_0000, 32'h0000_0000, 0, 0,     0,   0);
        add_row(-1,    32'hF400_0000, 32'h0199_999A, 0, 0,     0,   0);
        add_row(-1,    32'h0000_0000, 32'h1000_0000, 0, 0,     0,   0);
        add_row(-1,    32'hE800_0000, 32'h0800_0000, 0, 0,     0,   0);
        add_row(0,     32'h0000_0000, 32'h0000_0000, 1, 0,     0,   0);
        add_row(-1,    32'h7FFF_FFFF, 32'h8000_0000, 1, 0,     0,   0);
        add_row(1,     32'h0000_0000, 32'h0000_0000, 1, 1,     255, 0);
        add_row(-1,    32'h7FFF_FFFF, 32'h0000_0000, 1, 1,     255, 0);
        add_row(65535, 32'h0000_0000, 32'h0000_0000, 1, 65535, 255, 0);
        add_row(-1,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1,     0,   1);
        add_row(-1,    32'h0428_F5C3, 32'h0000_0000, 0, 0,     0,   0);
        add_row(255,   32'h2000_0000, 32'h0000_0000, 1, 2,     2,   1);
        add_row(-1,    32'hF400_0000, 32'h0199_999A, 0, 0,     0,   0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.limit >= 0)
                write_limit(mbet_pkg::COUNT_WIDTH'(row.limit));
            send_point(row.cr, row.ci,
                       row.known ? row.res : escape_time(row.cr, row.ci, iter_limit));
        end

        sent = 0;
        while (sent < 400)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_limit(mbet_pkg::COUNT_WIDTH'($urandom_range(1, 8)));
            else if (pick <= 6)
                write_limit(mbet_pkg::COUNT_WIDTH'($urandom_range(9, 80)));
            else if (pick == 7)
                write_limit(mbet_pkg::COUNT_WIDTH'($urandom_range(255, 256)));
            else
                write_limit(mbet_pkg::COUNT_WIDTH'($urandom_range(100, 400)));
            if ($urandom_range(0, 3) == 0)
            begin
                send_pct  = 0;
                stall_pct = 0;
            end
            else
            begin
                send_pct  = $urandom_range(10, 60);
                stall_pct = $urandom_range(10, 60);
            end
            n = $urandom_range(20, 50);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    cr = mbet_pkg::COORD_WIDTH'(-603979776
                                                + int'($urandom_range(0, 805306368)));
                    ci = mbet_pkg::COORD_WIDTH'(-402653184
                                                + int'($urandom_range(0, 805306368)));
                end
                else
                begin
                    cr = $urandom;
                    ci = $urandom;
                end
                send_point(cr, ci, escape_time(cr, ci, iter_limit));
                sent++;
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
